/* hw/rtl/bounded_top_k_binary_heap_assert.svh */
// Assertion macros for the bounded top-k heap.
// Used by bounded_top_k_binary_heap.sv; depends on nothing.
`ifndef BOUNDED_TOP_K_BINARY_HEAP_ASSERT_SVH
`define BOUNDED_TOP_K_BINARY_HEAP_ASSERT_SVH

// same-cycle implication
`define BTKH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTKH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/btkh_pkg.sv */
// Shared types and constants for the bounded top-k heap.
// Depends on nothing; used by bounded_top_k_binary_heap and tb.
package btkh_pkg;

	localparam int CAPACITY = 128;
	localparam int KEY_W    = 32;
	localparam int ID_W     = 32;
	localparam int ENT_W    = KEY_W + ID_W;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int AW       = $clog2(CAPACITY);
	localparam int LIM_W    = (CNT_W > 8) ? CNT_W : 8;

	localparam logic [7:0] LIMIT_RST = 8'd128;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] in_key;
		logic [ID_W-1:0]  in_ident;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		logic [ID_W-1:0]  out_ident;
		logic             out_valid;
		logic             accepted;
		logic [7:0]       fill_count;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  ident;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DLAST,
		ST_DL,
		ST_DR,
		ST_DC,
		ST_UP,
		ST_UPC,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/bounded_top_k_binary_heap.sv */
// Bounded binary min-heap of (key, ident) entries for top-k selection.
// Depends on btkh_pkg, btkh_ram and bounded_top_k_binary_heap_assert.svh.
//
// channel   direction  ports                     handshake
// command   in         cmd (cmd_t)               start && !busy
// result    out        result (result_t)         done, one cycle, no stall
// limit     in         heap_limit                heap_limit_we
//
// Peek, empty pop, dropped push and unused action read the root and finish.
// Push below the limit climbs from the new last position toward the root.
// Pop moves the last entry to the root and sinks it down the heap.
// A push into a full heap runs the pop descent then the climb.
// Each step is set by the one read port of the heap RAM, one access per cycle.
// Reset clears the count and restores the limit to 128; the RAM is not cleared.
`include "bounded_top_k_binary_heap_assert.svh"

module bounded_top_k_binary_heap
	import btkh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output result_t    result,
	input  logic       heap_limit_we,
	input  logic [7:0] heap_limit
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       lim_q;
	logic [1:0]       act_q;
	entry_t           in_ent_q;
	entry_t           node_q;
	entry_t           lent_q;
	logic [CNT_W-1:0] idx_q;
	logic [KEY_W-1:0] res_key_q;
	logic [ID_W-1:0]  res_id_q;
	logic             res_valid_q;
	logic             res_acc_q;

	logic             we;
	logic [AW-1:0]    waddr;
	entry_t           wdata;
	logic [AW-1:0]    raddr;
	entry_t           rdata;

	logic [LIM_W-1:0] lim_w, cap_w, lim_eff, cnt_w;
	logic             is_full;
	logic             push_ok;
	logic [CNT_W:0]   l_pos, r_pos, n_ext;
	logic             l_out, r_out;
	logic             take_left;
	logic [CNT_W:0]   c_pos;
	entry_t           c_ent;
	logic             stop_dn;
	logic             stop_up;
	logic             dn_end;
	logic [CNT_W-1:0] p_pos;
	logic [CNT_W-1:0] idx_m1, p_m1, cnt_m1;
	logic [CNT_W:0]   l_m1;
	logic [CNT_W-1:0] wr_pos;

	btkh_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign lim_w   = LIM_W'(lim_q);
	assign cap_w   = LIM_W'(CAPACITY);
	assign lim_eff = (lim_w == '0) ? LIM_W'(1) : ((lim_w > cap_w) ? cap_w : lim_w);
	assign cnt_w   = LIM_W'(cnt_q);
	assign is_full = cnt_w >= lim_eff;
	assign push_ok = in_ent_q.key >= rdata.key;

	assign l_pos     = (CNT_W+1)'(idx_q) << 1;
	assign r_pos     = l_pos + (CNT_W+1)'(1);
	assign n_ext     = (CNT_W+1)'(cnt_q);
	assign l_out     = l_pos > n_ext;
	assign r_out     = r_pos > n_ext;
	assign take_left = r_out || (lent_q.key < rdata.key);
	assign c_pos     = take_left ? l_pos : r_pos;
	assign c_ent     = take_left ? lent_q : rdata;
	assign stop_dn   = node_q.key <= c_ent.key;
	assign stop_up   = node_q.key >= rdata.key;
	assign p_pos     = idx_q >> 1;
	assign dn_end    = ((state_q == ST_DL) && l_out) || ((state_q == ST_DC) && stop_dn);

	assign idx_m1 = idx_q - CNT_W'(1);
	assign p_m1   = p_pos - CNT_W'(1);
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign l_m1   = l_pos - (CNT_W+1)'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				case (act_q)
					ACT_PUSH: begin
						if (!is_full) begin
							state_d = ST_UP;
						end else if (push_ok) begin
							state_d = ST_DLAST;
						end else begin
							state_d = ST_DONE;
						end
					end
					ACT_POP: begin
						state_d = (cnt_q != '0) ? ST_DLAST : ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_DLAST: begin
				state_d = ST_DL;
			end
			ST_DL: begin
				if (l_out) begin
					state_d = (act_q == ACT_PUSH) ? ST_UP : ST_DONE;
				end else begin
					state_d = ST_DR;
				end
			end
			ST_DR: begin
				state_d = ST_DC;
			end
			ST_DC: begin
				if (stop_dn) begin
					state_d = (act_q == ACT_PUSH) ? ST_UP : ST_DONE;
				end else begin
					state_d = ST_DL;
				end
			end
			ST_UP: begin
				state_d = (idx_q == CNT_W'(1)) ? ST_DONE : ST_UPC;
			end
			ST_UPC: begin
				state_d = stop_up ? ST_DONE : ST_UP;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory access
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = idx_m1[AW-1:0];
		wdata = node_q;
		case (state_q)
			ST_ROOT: begin
				raddr = cnt_m1[AW-1:0];
			end
			ST_DL: begin
				raddr = l_m1[AW-1:0];
				we    = l_out;
			end
			ST_DR: begin
				raddr = l_pos[AW-1:0];
			end
			ST_DC: begin
				we    = 1'b1;
				wdata = stop_dn ? node_q : c_ent;
			end
			ST_UP: begin
				raddr = p_m1[AW-1:0];
				we    = idx_q == CNT_W'(1);
			end
			ST_UPC: begin
				we    = 1'b1;
				wdata = stop_up ? node_q : rdata;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;

	assign result.out_key    = res_key_q;
	assign result.out_ident  = res_id_q;
	assign result.out_valid  = res_valid_q;
	assign result.accepted   = res_acc_q;
	assign result.fill_count = cnt_w[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lim_q   <= LIMIT_RST;
		end else begin
			state_q <= state_d;
			if (heap_limit_we) begin
				lim_q <= heap_limit;
			end
			if ((state_q == ST_ROOT) && (act_q == ACT_PUSH) && !is_full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (dn_end && (act_q != ACT_PUSH)) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					act_q          <= cmd.action;
					in_ent_q.key   <= cmd.in_key;
					in_ent_q.ident <= cmd.in_ident;
				end
			end
			ST_ROOT: begin
				res_key_q   <= '0;
				res_id_q    <= '0;
				res_valid_q <= 1'b0;
				res_acc_q   <= 1'b0;
				if (act_q == ACT_PUSH) begin
					if (!is_full) begin
						idx_q     <= cnt_q + CNT_W'(1);
						node_q    <= in_ent_q;
						res_acc_q <= 1'b1;
					end else if (push_ok) begin
						res_acc_q <= 1'b1;
					end
				end else if (((act_q == ACT_POP) || (act_q == ACT_PEEK)) && (cnt_q != '0)) begin
					res_key_q   <= rdata.key;
					res_id_q    <= rdata.ident;
					res_valid_q <= 1'b1;
				end
			end
			ST_DLAST: begin
				node_q <= rdata;
				idx_q  <= CNT_W'(1);
			end
			ST_DR: begin
				lent_q <= rdata;
			end
			ST_DC: begin
				if (!stop_dn) begin
					idx_q <= c_pos[CNT_W-1:0];
				end
			end
			ST_UPC: begin
				if (!stop_up) begin
					idx_q <= p_pos;
				end
			end
			default: begin
			end
		endcase
		// hand over to the climb of the pushed entry
		if (dn_end && (act_q == ACT_PUSH)) begin
			node_q <= in_ent_q;
			idx_q  <= cnt_q;
		end
	end

	assign wr_pos = CNT_W'(waddr) + CNT_W'(1);

	`BTKH_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY),
		"entry count above capacity")
	`BTKH_ASSERT_IMP(a_wr_in_heap, clk, arst_n, we, (wr_pos <= cnt_q) && (wr_pos != '0),
		"heap write outside occupied entries")
	`BTKH_ASSERT_NXT(a_accept_root, clk, arst_n, start && !busy, state_q == ST_ROOT,
		"accepted beat did not start a root read")
	`BTKH_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done && !busy,
		"result strobe longer than one cycle")
	`BTKH_ASSERT_IMP(a_res_excl, clk, arst_n, done, !(result.out_valid && result.accepted),
		"result both valid root and stored push")

endmodule

/* hw/rtl/btkh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module btkh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* test/tb.sv */
// Self-checking testbench for bounded_top_k_binary_heap: directed table, then random phases.
// Depends on btkh_pkg and the heap RTL; checks each result against a table value or its own heap model.
module tb;
	import btkh_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic       is_cfg;
		logic [7:0] lim;
		cmd_t       c;
		logic       typed;
		result_t    want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	cmd_t       cmd = '0;
	logic       done;
	result_t    result;
	logic       heap_limit_we = 1'b0;
	logic [7:0] heap_limit = 8'd0;

	entry_t      heap_mem [1:CAPACITY];
	int unsigned fill;
	logic [7:0]  lim_reg;

	result_t     pending_results [$];
	stim_row_t   directed_rows [$];
	int          err_count = 0;
	int          n_cmds = 0;
	int          n_results = 0;
	int          n_drops = 0;
	int          n_empty = 0;
	int          n_limits = 0;
	int          idle_pct = 0;

	bounded_top_k_binary_heap uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.done         (done),
		.result       (result),
		.heap_limit_we(heap_limit_we),
		.heap_limit   (heap_limit)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned lim_eff();
		int unsigned l;
		l = 32'(lim_reg);
		if (l == 0) l = 1;
		if (l > CAPACITY) l = CAPACITY;
		return l;
	endfunction

	// move entry n to the root and sink it over positions 1..n
	function automatic void sink_last(int unsigned n);
		entry_t      node;
		int unsigned i, l, r, c;
		node = heap_mem[n];
		i = 1;
		while (1) begin
			l = 2 * i;
			r = l + 1;
			if (l > n) break;
			if (r > n || heap_mem[l].key < heap_mem[r].key) c = l;
			else c = r;
			if (node.key <= heap_mem[c].key) break;
			heap_mem[i] = heap_mem[c];
			i = c;
		end
		heap_mem[i] = node;
	endfunction

	function automatic void float_up(int unsigned n, entry_t node);
		int unsigned i, p;
		i = n;
		while (i > 1) begin
			p = i >> 1;
			if (node.key >= heap_mem[p].key) break;
			heap_mem[i] = heap_mem[p];
			i = p;
		end
		heap_mem[i] = node;
	endfunction

	function automatic result_t predict_heap(cmd_t c);
		result_t r;
		entry_t  node;
		r = '0;
		node.key = c.in_key;
		node.ident = c.in_ident;
		case (c.action)
			ACT_PUSH: begin
				if (fill >= lim_eff()) begin
					if (c.in_key >= heap_mem[1].key) begin
						sink_last(fill);
						float_up(fill, node);
						r.accepted = 1'b1;
					end
				end else begin
					fill++;
					float_up(fill, node);
					r.accepted = 1'b1;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (fill > 0) begin
					r.out_key = heap_mem[1].key;
					r.out_ident = heap_mem[1].ident;
					r.out_valid = 1'b1;
					if (c.action == ACT_POP) begin
						sink_last(fill);
						fill--;
					end
				end
			end
			default: ;
		endcase
		r.fill_count = fill[7:0];
		return r;
	endfunction

	function automatic result_t res(logic [31:0] k, logic [31:0] id, logic v, logic a,
			logic [7:0] f);
		result_t r;
		r.out_key = k;
		r.out_ident = id;
		r.out_valid = v;
		r.accepted = a;
		r.fill_count = f;
		return r;
	endfunction

	function automatic stim_row_t row(logic is_cfg, logic [7:0] lim, logic [1:0] act,
			logic [31:0] k, logic [31:0] id, logic typed, result_t want);
		stim_row_t s;
		s.is_cfg = is_cfg;
		s.lim = lim;
		s.c.action = act;
		s.c.in_key = k;
		s.c.in_ident = id;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	function automatic void add_row(stim_row_t s);
		directed_rows.insert(directed_rows.size(), s);
	endfunction

	function automatic void expect_beat(result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3, 4, 5: return $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic issue(cmd_t c, logic typed, result_t typed_want);
		result_t want;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		want = predict_heap(c);
		if (c.action == ACT_PUSH && !want.accepted) n_drops++;
		if ((c.action == ACT_POP || c.action == ACT_PEEK) && !want.out_valid) n_empty++;
		expect_beat(typed ? typed_want : want);
		n_cmds++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
		end
	endtask

	// drain, let the block settle, then write the limit
	task automatic set_limit(logic [7:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		heap_limit_we <= 1'b1;
		heap_limit <= v;
		@(posedge clk);
		heap_limit_we <= 1'b0;
		lim_reg = v;
		n_limits++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat, out_key", result.out_key, 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (result.out_key !== want.out_key)
					report_mismatch("out_key", result.out_key, want.out_key);
				if (result.out_ident !== want.out_ident)
					report_mismatch("out_ident", result.out_ident, want.out_ident);
				if (result.out_valid !== want.out_valid)
					report_mismatch("out_valid", result.out_valid, want.out_valid);
				if (result.accepted !== want.accepted)
					report_mismatch("accepted", result.accepted, want.accepted);
				if (result.fill_count !== want.fill_count)
					report_mismatch("fill_count", result.fill_count, want.fill_count);
			end
		end
	end

	initial begin : stimulus
		stim_row_t   rw;
		cmd_t        c;
		logic [7:0]  lim;
		int unsigned pick, push_pct;
		fill = 0;
		lim_reg = LIMIT_RST;
		add_row(row(0, 0, ACT_PEEK, 0, 0, 1, res(0, 0, 0, 0, 0)));
		add_row(row(0, 0, ACT_POP, 0, 0, 1, res(0, 0, 0, 0, 0)));
		add_row(row(0, 0, ACT_NONE, '1, '1, 1, res(0, 0, 0, 0, 0)));
		add_row(row(0, 0, ACT_PUSH, '1, 0, 1, res(0, 0, 0, 1, 1)));
		add_row(row(0, 0, ACT_PUSH, 0, '1, 1, res(0, 0, 0, 1, 2)));
		add_row(row(0, 0, ACT_PEEK, 0, 0, 1, res(0, '1, 1, 0, 2)));
		add_row(row(0, 0, ACT_PUSH, 5, 32'h5555_5555, 0, '0));
		add_row(row(0, 0, ACT_PUSH, 5, 32'hAAAA_AAAA, 0, '0));
		add_row(row(0, 0, ACT_PUSH, 5, 32'h1234_5678, 0, '0));
		add_row(row(0, 0, ACT_PUSH, 5, 32'h0000_FFFF, 0, '0));
		add_row(row(0, 0, ACT_NONE, 7, 9, 1, res(0, 0, 0, 0, 6)));
		add_row(row(1, 8'd0, ACT_NONE, 0, 0, 0, '0));
		add_row(row(0, 0, ACT_POP, 0, 0, 1, res(0, '1, 1, 0, 5)));
		add_row(row(0, 0, ACT_PUSH, 4, 1, 1, res(0, 0, 0, 0, 5)));
		add_row(row(0, 0, ACT_PUSH, 5, 2, 0, '0));
		add_row(row(0, 0, ACT_PUSH, '1, 3, 0, '0));
		add_row(row(0, 0, ACT_PEEK, 0, 0, 0, '0));
		add_row(row(1, 8'd255, ACT_NONE, 0, 0, 0, '0));
		add_row(row(0, 0, ACT_PUSH, 3, 4, 0, '0));
		add_row(row(1, 8'd2, ACT_NONE, 0, 0, 0, '0));
		repeat (6) add_row(row(0, 0, ACT_POP, 0, 0, 0, '0));
		add_row(row(0, 0, ACT_POP, 0, 0, 1, res(0, 0, 0, 0, 0)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			rw = directed_rows[i];
			if (rw.is_cfg) set_limit(rw.lim);
			else issue(rw.c, rw.typed, rw.want);
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: lim = 8'd128;
				1: lim = 8'd1;
				2: lim = 8'd2;
				3: lim = 8'd0;
				4: lim = 8'd255;
				5: lim = 8'd7;
				6: lim = 8'd3;
				default: lim = 8'($urandom_range(4, 127));
			endcase
			set_limit(lim);
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 84;
				default: idle_pct = 6;
			endcase
			for (int n = 0; n < 240; n++) begin
				push_pct = (n < 168) ? 85 : 20;
				pick = $urandom_range(0, 99);
				if (pick < push_pct) begin
					c.action = ACT_PUSH;
				end else begin
					pick = $urandom_range(0, 19);
					if (pick < 12) c.action = ACT_POP;
					else if (pick < 17) c.action = ACT_PEEK;
					else c.action = ACT_NONE;
				end
				c.in_key = rand_key();
				c.in_ident = $urandom();
				issue(c, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d commands over %0d limit settings, checked %0d results.",
			n_cmds, n_limits, n_results);
		$display("Pushes dropped against the root: %0d; pops or peeks on an empty heap: %0d.",
			n_drops, n_empty);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
